@@ sv/c2c_pkg.sv @@
package c2c_pkg;

  localparam int FIELD_VNUM_W  = 17;
  localparam int FIELD_ENUM_W  = 11;
  localparam int FIELD_IDX_W   = 13;
  localparam int FIELD_STAT_W  = 3;
  localparam int FIELD_VALUE_W = 16;

  localparam logic [1:0] FN_LOAD   = 2'd0;
  localparam logic [1:0] FN_FINISH = 2'd1;
  localparam logic [1:0] FN_RD_OFF = 2'd2;
  localparam logic [1:0] FN_RD_PIN = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_VERT  = 3'd1;
  localparam logic [2:0] ST_BAD_EDGE  = 3'd2;
  localparam logic [2:0] ST_TOO_MANY  = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  localparam logic [1:0] REG_NUM_VERTICES = 2'd0;
  localparam logic [1:0] REG_NUM_EDGES    = 2'd1;
  localparam logic [1:0] REG_NUM_ENTRIES  = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic [FIELD_VNUM_W-1:0]  vertex_number;
    logic [FIELD_ENUM_W-1:0]  edge_number;
    logic [FIELD_IDX_W-1:0]   read_index;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_STAT_W-1:0]  status;
    logic [FIELD_VALUE_W-1:0] read_value;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic clr_we;
    logic ld_commit;
    logic rd_cap;
    logic pre_rd;
    logic pre_wr;
    logic pre_end;
    logic sc_rd;
    logic sc_cur;
    logic sc_wr;
    logic post;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] in_func;
    logic       in_ok;
    logic       pre_done;
    logic       sc_done;
    logic       clr_last;
    logic       out_free;
  } stat_t;

endpackage

@@ sv/c2c_ram.sv @@
module c2c_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/c2c_ctrl.sv @@
module c2c_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  c2c_pkg::stat_t st,
  output c2c_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_LD_WR  = 10'b00_0000_0100,
    S_RD_CAP = 10'b00_0000_1000,
    S_PRE_RD = 10'b00_0001_0000,
    S_PRE_WR = 10'b00_0010_0000,
    S_SC_RD  = 10'b00_0100_0000,
    S_SC_CUR = 10'b00_1000_0000,
    S_SC_WR  = 10'b01_0000_0000,
    S_RESP   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (st.in_func) inside
            c2c_pkg::FN_LOAD:   state_nxt = st.in_ok ? S_LD_WR : S_RESP;
            c2c_pkg::FN_FINISH: state_nxt = S_PRE_RD;
            c2c_pkg::FN_RD_OFF, c2c_pkg::FN_RD_PIN:
              state_nxt = st.in_ok ? S_RD_CAP : S_RESP;
            default:            state_nxt = S_RESP;
          endcase
        end
      end
      S_LD_WR: begin
        cmd.ld_commit = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RD_CAP: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_RESP;
      end
      S_PRE_RD: begin
        if (st.pre_done) begin
          cmd.pre_end = 1'b1;
          state_nxt   = S_SC_RD;
        end else begin
          cmd.pre_rd = 1'b1;
          state_nxt  = S_PRE_WR;
        end
      end
      S_PRE_WR: begin
        cmd.pre_wr = 1'b1;
        state_nxt  = S_PRE_RD;
      end
      S_SC_RD: begin
        if (st.sc_done) begin
          state_nxt = S_RESP;
        end else begin
          cmd.sc_rd = 1'b1;
          state_nxt = S_SC_CUR;
        end
      end
      S_SC_CUR: begin
        cmd.sc_cur = 1'b1;
        state_nxt  = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.sc_wr = 1'b1;
        state_nxt = S_SC_RD;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

@@ sv/c2c_dp.sv @@
module c2c_dp #(
  parameter int MAX_EDGES    = 1024,
  parameter int MAX_ENTRIES  = 4096,
  parameter int MAX_VERTICES = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  c2c_pkg::cmd_t       cmd,
  output c2c_pkg::stat_t      st,
  input  c2c_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output c2c_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int VW  = c2c_pkg::FIELD_VNUM_W;
  localparam int EW  = c2c_pkg::FIELD_ENUM_W;
  localparam int IW  = c2c_pkg::FIELD_IDX_W;
  localparam int DW  = c2c_pkg::FIELD_VALUE_W;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SAW = $clog2(MAX_EDGES + 1);
  localparam int PAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int PTW = (SAW > CW) ? SAW : CW;

  // Register caps; a cap beyond a register's range is never selected.
  localparam logic [VW-1:0] CAP_V = VW'(MAX_VERTICES);
  localparam logic [EW-1:0] CAP_E = EW'(MAX_EDGES);
  localparam logic [IW-1:0] CAP_P = IW'(MAX_ENTRIES);

  logic [VW-1:0]  nv_r;
  logic [EW-1:0]  ne_r;
  logic [IW-1:0]  np_r;
  logic [VW-1:0]  nv_eff;
  logic [EW-1:0]  ne_eff;
  logic [IW-1:0]  np_eff;

  logic [CW-1:0]  loaded_r;
  logic [PTW-1:0] ptr_r;
  logic [CW-1:0]  sum_r;
  logic [1:0]     func_r;
  logic [2:0]     stat_r;
  logic [DW-1:0]  value_r;
  logic [EAW-1:0] edge_idx_r;
  logic [DW-1:0]  sc_v_r;
  logic [EAW-1:0] sc_e_r;
  logic           sc_ok_r;
  logic           out_valid_r;
  c2c_pkg::out_item_t out_data_r;

  logic [2:0]     chk_status;
  logic           load_ok;
  logic           cfg_wr;

  // Memory ports.
  logic           cnt_we;
  logic [EAW-1:0] cnt_addr;
  logic [CW-1:0]  cnt_wdata, cnt_q;
  logic           start_we;
  logic [SAW-1:0] start_addr;
  logic [CW-1:0]  start_q;
  logic           cur_we;
  logic [EAW-1:0] cur_addr;
  logic [CW-1:0]  cur_wdata, cur_q;
  logic           held_we;
  logic [PAW-1:0] held_addr;
  logic [DW+EAW-1:0] held_wdata, held_q;
  logic           pin_we;
  logic [PAW-1:0] pin_addr;
  logic [DW-1:0]  pin_q;

  assign nv_eff = (32'(nv_r) > MAX_VERTICES) ? CAP_V : nv_r;
  assign ne_eff = (32'(ne_r) > MAX_EDGES)    ? CAP_E : ne_r;
  assign np_eff = (32'(np_r) > MAX_ENTRIES)  ? CAP_P : np_r;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= '0;
      ne_r <= '0;
      np_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        c2c_pkg::REG_NUM_VERTICES: nv_r <= pwdata[VW-1:0];
        c2c_pkg::REG_NUM_EDGES:    ne_r <= pwdata[EW-1:0];
        c2c_pkg::REG_NUM_ENTRIES:  np_r <= pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      c2c_pkg::REG_NUM_VERTICES: prdata = 32'(nv_r);
      c2c_pkg::REG_NUM_EDGES:    prdata = 32'(ne_r);
      c2c_pkg::REG_NUM_ENTRIES:  prdata = 32'(np_r);
      default:                   prdata = '0;
    endcase
  end

  // Item check, evaluated on the incoming item.
  always_comb begin
    chk_status = c2c_pkg::ST_OK;
    case (in_data.func)
      c2c_pkg::FN_LOAD: begin
        if (32'(loaded_r) >= 32'(np_eff)) begin
          chk_status = c2c_pkg::ST_TOO_MANY;
        end else if (in_data.vertex_number == '0 || in_data.vertex_number > nv_eff) begin
          chk_status = c2c_pkg::ST_BAD_VERT;
        end else if (in_data.edge_number == '0 || in_data.edge_number > ne_eff) begin
          chk_status = c2c_pkg::ST_BAD_EDGE;
        end
      end
      c2c_pkg::FN_RD_OFF: begin
        if (32'(in_data.read_index) > 32'(ne_eff)) begin
          chk_status = c2c_pkg::ST_BAD_INDEX;
        end
      end
      c2c_pkg::FN_RD_PIN: begin
        if (in_data.read_index >= np_eff) begin
          chk_status = c2c_pkg::ST_BAD_INDEX;
        end
      end
      default: ;
    endcase
  end

  assign load_ok = cmd.take && (in_data.func == c2c_pkg::FN_LOAD) &&
                   (chk_status == c2c_pkg::ST_OK);

  assign st.in_func  = in_data.func;
  assign st.in_ok    = (chk_status == c2c_pkg::ST_OK);
  assign st.pre_done = (32'(ptr_r) == 32'(ne_eff));
  assign st.sc_done  = (32'(ptr_r) == 32'(loaded_r));
  assign st.clr_last = (32'(ptr_r) == MAX_EDGES - 1);
  assign st.out_free = !out_valid_r || out_ready;

  // Per-hyperedge counts.
  assign cnt_we    = cmd.clr_we || cmd.ld_commit;
  assign cnt_wdata = cmd.clr_we ? '0 : CW'(cnt_q + 1'b1);
  always_comb begin
    if (cmd.clr_we || cmd.pre_rd) begin
      cnt_addr = EAW'(ptr_r);
    end else if (cmd.ld_commit) begin
      cnt_addr = edge_idx_r;
    end else begin
      cnt_addr = EAW'(in_data.edge_number - 1'b1);
    end
  end

  // Start offsets.
  assign start_we   = cmd.pre_wr || cmd.pre_end;
  assign start_addr = start_we ? SAW'(ptr_r) : SAW'(in_data.read_index);

  // Fill cursors for the scatter.
  assign cur_we    = cmd.pre_wr || (cmd.sc_wr && sc_ok_r);
  assign cur_wdata = cmd.pre_wr ? sum_r : CW'(cur_q + 1'b1);
  always_comb begin
    if (cmd.pre_wr) begin
      cur_addr = EAW'(ptr_r);
    end else if (cmd.sc_wr) begin
      cur_addr = sc_e_r;
    end else begin
      cur_addr = held_q[EAW-1:0];
    end
  end

  // Held entries, vertex above hyperedge.
  assign held_we    = load_ok;
  assign held_addr  = cmd.sc_rd ? PAW'(ptr_r) : PAW'(loaded_r);
  assign held_wdata = {DW'(in_data.vertex_number - 1'b1),
                       EAW'(in_data.edge_number - 1'b1)};

  // Pin list.
  assign pin_we   = cmd.sc_wr && sc_ok_r && (32'(cur_q) < MAX_ENTRIES);
  assign pin_addr = cmd.sc_wr ? PAW'(cur_q) : PAW'(in_data.read_index);

  c2c_ram #(.WIDTH(CW), .DEPTH(MAX_EDGES), .AW(EAW)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_q)
  );

  c2c_ram #(.WIDTH(CW), .DEPTH(MAX_EDGES + 1), .AW(SAW)) u_start_ram (
    .clk(clk), .we(start_we), .addr(start_addr), .wdata(sum_r), .rdata(start_q)
  );

  c2c_ram #(.WIDTH(CW), .DEPTH(MAX_EDGES), .AW(EAW)) u_cur_ram (
    .clk(clk), .we(cur_we), .addr(cur_addr), .wdata(cur_wdata), .rdata(cur_q)
  );

  c2c_ram #(.WIDTH(DW + EAW), .DEPTH(MAX_ENTRIES), .AW(PAW)) u_held_ram (
    .clk(clk), .we(held_we), .addr(held_addr), .wdata(held_wdata), .rdata(held_q)
  );

  c2c_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES), .AW(PAW)) u_pin_ram (
    .clk(clk), .we(pin_we), .addr(pin_addr), .wdata(sc_v_r), .rdata(pin_q)
  );

  // Control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      ptr_r    <= '0;
    end else begin
      if (load_ok) begin
        loaded_r <= CW'(loaded_r + 1'b1);
      end
      if (cmd.take && in_data.func == c2c_pkg::FN_FINISH) begin
        ptr_r <= '0;
      end else if (cmd.pre_end) begin
        ptr_r <= '0;
      end else if (cmd.clr_we || cmd.pre_wr || cmd.sc_wr) begin
        ptr_r <= PTW'(ptr_r + 1'b1);
      end
    end
  end

  // Item and walk payload.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_r     <= in_data.func;
      stat_r     <= chk_status;
      value_r    <= '0;
      edge_idx_r <= EAW'(in_data.edge_number - 1'b1);
      sum_r      <= '0;
    end
    if (cmd.pre_wr) begin
      sum_r <= CW'(sum_r + cnt_q);
    end
    if (cmd.rd_cap) begin
      value_r <= (func_r == c2c_pkg::FN_RD_OFF) ? DW'(start_q) : pin_q;
    end
    if (cmd.sc_cur) begin
      sc_v_r  <= held_q[DW+EAW-1:EAW];
      sc_e_r  <= held_q[EAW-1:0];
      sc_ok_r <= (32'(held_q[EAW-1:0]) < 32'(ne_eff));
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.post) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_data_r.status     <= stat_r;
      out_data_r.read_value <= value_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/coordinate_to_compressed_builder.sv @@
// Channel   Direction  Handshake           Transaction
// in_       input      in_valid/in_ready   one load, finish or read item
// out_      output     out_valid/out_ready one status and read value per item
// cfg       input      APB psel/penable    write or read of one count register
//
// A load passes through acceptance, count update in the per-hyperedge
// count memory, and the result post. A read passes through acceptance, a
// capture of the registered memory read, and the result post. A rejected
// item goes from acceptance straight to the result post. A finish for E
// hyperedges and L held entries runs through the acceptance, a count memory
// read and offset write per hyperedge, the closing offset, a held entry read,
// a cursor read and a pin write per entry, the end of the walk and the result
// post. After reset a clearing pass writes zero to every count entry, one per
// cycle; in_ready stays low meanwhile while configuration writes are taken.
// A transaction on the input is taken while an earlier result still waits
// in the output register; a stalled output holds the next result in the
// controller's response state.
module coordinate_to_compressed_builder #(
  parameter int MAX_EDGES    = 1024,
  parameter int MAX_ENTRIES  = 4096,
  parameter int MAX_VERTICES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  c2c_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output c2c_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // The controller sequences each transaction; the datapath holds the
  // registers, the checks and the five memories.
  c2c_pkg::cmd_t  cmd;
  c2c_pkg::stat_t st;

  c2c_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath counts entries per hyperedge on load, prefix-sums the counts
  // into start offsets on finish and then scatters the held vertices into
  // the pin list in load order, using a second copy of the offsets as cursors.
  c2c_dp #(
    .MAX_EDGES    (MAX_EDGES),
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

endmodule

@@ sv/c2c_checker.sv @@
module c2c_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input c2c_pkg::out_item_t out_data
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Each accepted transaction occupies the block, so in_ready is low after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= c2c_pkg::ST_BAD_INDEX)
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != c2c_pkg::ST_OK |-> out_data.read_value == '0)
    else $error("rejected transaction carries a value");

endmodule

bind coordinate_to_compressed_builder c2c_checker u_c2c_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
